FILE: sv/i2cap_pkg.sv
// ----------------------------------------------------------------------------
// i2cap_pkg
// Types and constants for the I2C address probe master.
// ----------------------------------------------------------------------------
package i2cap_pkg;

    localparam int unsigned ADDR_W  = 7;
    localparam int unsigned DELAY_W = 8;
    localparam int unsigned BIT_W   = 3;

    localparam logic [DELAY_W-1:0] DELAY_RESET = 8'd4;
    localparam logic [BIT_W-1:0]   LAST_BIT    = 3'd7;
    localparam logic [7:0]         MSB_MASK    = 8'h80;

    // one-hot sequencer steps
    typedef enum logic [9:0] {
        ST_IDLE     = 10'b00_0000_0001,
        ST_START_HI = 10'b00_0000_0010,
        ST_START_LO = 10'b00_0000_0100,
        ST_BIT_LOW  = 10'b00_0000_1000,
        ST_BIT_HIGH = 10'b00_0001_0000,
        ST_ACK_LOW  = 10'b00_0010_0000,
        ST_ACK_HIGH = 10'b00_0100_0000,
        ST_STOP_A   = 10'b00_1000_0000,
        ST_STOP_B   = 10'b01_0000_0000,
        ST_STOP_C   = 10'b10_0000_0000
    } step_t;

    typedef struct packed {
        logic              go;
        logic [ADDR_W-1:0] address;
        logic              sda_in;
    } cmd_item_t;

    typedef struct packed {
        logic scl_out;
        logic sda_out;
        logic busy_res;
        logic done_res;
        logic nack;
    } res_item_t;

endpackage

FILE: sv/i2cap_if.sv
// ----------------------------------------------------------------------------
// i2cap_if
// Valid/ready channels for tick items and result items.
// ----------------------------------------------------------------------------
interface i2cap_cmd_if
    import i2cap_pkg::*;
();
    logic      valid;
    logic      ready;
    cmd_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface i2cap_res_if
    import i2cap_pkg::*;
();
    logic      valid;
    logic      ready;
    res_item_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: sv/i2cap_seq.sv
// ----------------------------------------------------------------------------
// i2cap_seq
// Bus sequencer state, advanced by one tick per accepted transaction.
// ----------------------------------------------------------------------------
module i2cap_seq
    import i2cap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [DELAY_W-1:0] cfg_wr_data,
    input  logic               tick,
    input  cmd_item_t          item,
    output res_item_t          result
);

    logic [DELAY_W-1:0] delay_ticks_reg;
    step_t              step_reg,  step_next;
    logic [BIT_W-1:0]   bit_reg,   bit_next;
    logic [7:0]         shift_reg, shift_next;
    logic [DELAY_W-1:0] count_reg, count_next;
    logic               ack_reg,   ack_next;
    logic               scl_reg,   scl_next;
    logic               sda_reg,   sda_next;
    logic               done;
    logic               enter;
    step_t              target;
    logic [DELAY_W-1:0] reload;

    assign reload = (delay_ticks_reg == '0) ? DELAY_W'(1) : delay_ticks_reg;

    always_comb
    begin
        step_next  = step_reg;
        bit_next   = bit_reg;
        shift_next = shift_reg;
        count_next = count_reg;
        ack_next   = ack_reg;
        scl_next   = scl_reg;
        sda_next   = sda_reg;
        done       = 1'b0;
        enter      = 1'b0;
        target     = ST_IDLE;

        if (step_reg == ST_IDLE)
        begin
            if (item.go)
            begin
                shift_next = {item.address, 1'b0};
                bit_next   = '0;
                enter      = 1'b1;
                target     = ST_START_HI;
            end
        end
        else if (count_reg > DELAY_W'(1))
        begin
            count_next = count_reg - DELAY_W'(1);
        end
        else
        begin
            enter = 1'b1;
            unique case (step_reg)
                ST_START_HI: target = ST_START_LO;
                ST_START_LO: target = ST_BIT_LOW;
                ST_BIT_LOW:  target = ST_BIT_HIGH;
                ST_BIT_HIGH:
                begin
                    if (bit_reg >= LAST_BIT)
                    begin
                        target = ST_ACK_LOW;
                    end
                    else
                    begin
                        bit_next   = bit_reg + BIT_W'(1);
                        shift_next = {shift_reg[6:0], 1'b0};
                        target     = ST_BIT_LOW;
                    end
                end
                ST_ACK_LOW:  target = ST_ACK_HIGH;
                ST_ACK_HIGH: target = ST_STOP_A;
                ST_STOP_A:   target = ST_STOP_B;
                ST_STOP_B:   target = ST_STOP_C;
                default:
                begin
                    // end of stop, or an unknown code: back to idle
                    enter      = 1'b0;
                    step_next  = ST_IDLE;
                    count_next = '0;
                    done       = (step_reg == ST_STOP_C);
                end
            endcase
        end

        if (enter)
        begin
            step_next  = target;
            count_next = reload;
            unique case (target)
                ST_START_HI:
                begin
                    scl_next = 1'b1;
                    sda_next = 1'b1;
                end
                ST_START_LO: sda_next = 1'b0;
                ST_BIT_LOW:
                begin
                    scl_next = 1'b0;
                    sda_next = |(shift_next & MSB_MASK);
                end
                ST_BIT_HIGH: scl_next = 1'b1;
                ST_ACK_LOW:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b1;
                end
                ST_ACK_HIGH:
                begin
                    scl_next = 1'b1;
                    ack_next = item.sda_in;
                end
                ST_STOP_A:
                begin
                    scl_next = 1'b0;
                    sda_next = 1'b0;
                end
                ST_STOP_B:   scl_next = 1'b1;
                ST_STOP_C:   sda_next = 1'b1;
                default:     ;
            endcase
        end
    end

    assign result.scl_out  = scl_next;
    assign result.sda_out  = sda_next;
    assign result.busy_res = (step_next != ST_IDLE);
    assign result.done_res = done;
    assign result.nack     = ack_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            delay_ticks_reg <= DELAY_RESET;
            step_reg        <= ST_IDLE;
            bit_reg         <= '0;
            shift_reg       <= '0;
            count_reg       <= '0;
            ack_reg         <= 1'b1;
            scl_reg         <= 1'b1;
            sda_reg         <= 1'b1;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                delay_ticks_reg <= cfg_wr_data;
            end
            if (tick)
            begin
                step_reg  <= step_next;
                bit_reg   <= bit_next;
                shift_reg <= shift_next;
                count_reg <= count_next;
                ack_reg   <= ack_next;
                scl_reg   <= scl_next;
                sda_reg   <= sda_next;
            end
        end
    end

endmodule

FILE: sv/i2cap_out_reg.sv
// ----------------------------------------------------------------------------
// i2cap_out_reg
// Result register; loads whenever it is empty or being drained.
// ----------------------------------------------------------------------------
module i2cap_out_reg
    import i2cap_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        load,
    input  res_item_t   result,
    output logic        can_load,
    i2cap_res_if.source res
);

    logic      valid_reg;
    res_item_t data_reg;

    assign can_load  = !valid_reg || res.ready;
    assign res.valid = valid_reg;
    assign res.data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            data_reg <= result;
        end
    end

endmodule

FILE: sv/i2c_address_probe_master.sv
// Latency: a result is valid the cycle after its tick transaction is accepted.
// Throughput: one tick per cycle while the result register can load; the sequencer
// update for a tick is a single pass of logic into the state registers and the result register.
// A tick is accepted whenever the result register is empty or being drained.
// Reset (rst_n low, asynchronous): sequencer idle, lines released, nack 1,
// delay_ticks 4, no result pending.
// ----------------------------------------------------------------------------
// i2c_address_probe_master
// I2C master that probes whether a 7-bit slave address acknowledges.
// ----------------------------------------------------------------------------
module i2c_address_probe_master
    import i2cap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [DELAY_W-1:0] cfg_wr_data,
    i2cap_cmd_if.sink          cmd,
    i2cap_res_if.source        res
);

    logic      tick;
    logic      can_load;
    res_item_t result;

    assign cmd.ready = can_load;
    assign tick      = cmd.valid && can_load;

    i2cap_seq u_seq (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .tick        (tick),
        .item        (cmd.data),
        .result      (result)
    );

    i2cap_out_reg u_out (
        .clk      (clk),
        .rst_n    (rst_n),
        .load     (tick),
        .result   (result),
        .can_load (can_load),
        .res      (res)
    );

endmodule

FILE: sv/i2cap_checker.sv
// ----------------------------------------------------------------------------
// i2cap_checker
// Port-level checks for the I2C address probe master.
// ----------------------------------------------------------------------------
module i2cap_assertions
    import i2cap_pkg::*;
(
    input logic      clk,
    input logic      rst_n,
    input logic      cmd_ready,
    input logic      res_valid,
    input logic      res_ready,
    input res_item_t res_data
);

    // a stalled result must not let a new tick in
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |-> !cmd_ready)
        else $error("tick accepted while result stalled");

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_data.done_res |-> !res_data.busy_res)
        else $error("done reported while busy");

    a_idle_released: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_data.busy_res |-> res_data.scl_out && res_data.sda_out)
        else $error("bus lines not released while idle");

    a_res_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid && $stable(res_data))
        else $error("stalled result changed");

endmodule

bind i2c_address_probe_master i2cap_assertions u_i2cap_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd_ready (cmd.ready),
    .res_valid (res.valid),
    .res_ready (res.ready),
    .res_data  (res.data)
);

FILE: tb/i2cap_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cap_checker
// Watches the tick and result channels and the delay register writes, runs a
// tick-accurate model of the probe sequencer and compares every result.
// ----------------------------------------------------------------------------
module i2cap_checker
    import i2cap_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_wr_en,
    input  logic [DELAY_W-1:0] cfg_wr_data,
    i2cap_cmd_if               cmd,
    i2cap_res_if               res,
    output int                 mismatches,
    output int                 pending
);

    logic [DELAY_W-1:0] delay_ticks;
    step_t              step;
    logic [BIT_W-1:0]   bit_idx;
    logic [7:0]         shift_reg;
    logic [DELAY_W-1:0] count;
    logic               ack_bit;
    logic               scl_lvl;
    logic               sda_lvl;

    res_item_t expected_res[$];
    int        err_count = 0;
    int        queued    = 0;

    assign mismatches = err_count;
    assign pending    = queued;

    function automatic void enter_step(step_t s, logic sda_sample);
        step  = s;
        count = (delay_ticks == '0) ? DELAY_W'(1) : delay_ticks;
        case (s)
            ST_START_HI:
            begin
                scl_lvl = 1'b1;
                sda_lvl = 1'b1;
            end
            ST_START_LO: sda_lvl = 1'b0;
            ST_BIT_LOW:
            begin
                scl_lvl = 1'b0;
                sda_lvl = (shift_reg & MSB_MASK) != 8'h00;
            end
            ST_BIT_HIGH: scl_lvl = 1'b1;
            ST_ACK_LOW:
            begin
                scl_lvl = 1'b0;
                sda_lvl = 1'b1;
            end
            ST_ACK_HIGH:
            begin
                scl_lvl = 1'b1;
                ack_bit = sda_sample;
            end
            ST_STOP_A:
            begin
                scl_lvl = 1'b0;
                sda_lvl = 1'b0;
            end
            ST_STOP_B: scl_lvl = 1'b1;
            ST_STOP_C: sda_lvl = 1'b1;
            default: ;
        endcase
    endfunction

    // advance the sequencer by one tick and return the result it reports
    function automatic res_item_t probe_tick(cmd_item_t t);
        res_item_t r;
        logic      done;
        done = 1'b0;
        if (step == ST_IDLE)
        begin
            if (t.go)
            begin
                shift_reg = {t.address, 1'b0};
                bit_idx   = '0;
                enter_step(ST_START_HI, t.sda_in);
            end
        end
        else if (count > 1)
        begin
            count = count - 1'b1;
        end
        else
        begin
            case (step)
                ST_START_HI: enter_step(ST_START_LO, t.sda_in);
                ST_START_LO: enter_step(ST_BIT_LOW, t.sda_in);
                ST_BIT_LOW:  enter_step(ST_BIT_HIGH, t.sda_in);
                ST_BIT_HIGH:
                begin
                    if (bit_idx >= LAST_BIT)
                    begin
                        enter_step(ST_ACK_LOW, t.sda_in);
                    end
                    else
                    begin
                        bit_idx   = bit_idx + 1'b1;
                        shift_reg = shift_reg << 1;
                        enter_step(ST_BIT_LOW, t.sda_in);
                    end
                end
                ST_ACK_LOW:  enter_step(ST_ACK_HIGH, t.sda_in);
                ST_ACK_HIGH: enter_step(ST_STOP_A, t.sda_in);
                ST_STOP_A:   enter_step(ST_STOP_B, t.sda_in);
                ST_STOP_B:   enter_step(ST_STOP_C, t.sda_in);
                default:
                begin
                    step  = ST_IDLE;
                    count = '0;
                    done  = 1'b1;
                end
            endcase
        end
        r.scl_out  = scl_lvl;
        r.sda_out  = sda_lvl;
        r.busy_res = (step != ST_IDLE);
        r.done_res = done;
        r.nack     = ack_bit;
        return r;
    endfunction

    function automatic void check_field(string field, logic want, logic got);
        if (got !== want)
        begin
            err_count++;
            $display("%0t: %s expected %0b, got %0b", $time, field, want, got);
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        res_item_t want;
        if (!rst_n)
        begin
            delay_ticks = DELAY_RESET;
            step        = ST_IDLE;
            bit_idx     = '0;
            shift_reg   = '0;
            count       = '0;
            ack_bit     = 1'b1;
            scl_lvl     = 1'b1;
            sda_lvl     = 1'b1;
            expected_res.delete();
        end
        else
        begin
            // drain first: a result here always belongs to an older transaction
            if (res.valid && res.ready)
            begin
                if (expected_res.size() == 0)
                begin
                    err_count++;
                    $display("%0t: result %p with no transaction waiting", $time, res.data);
                end
                else
                begin
                    want = expected_res.pop_front();
                    check_field("scl_out", want.scl_out, res.data.scl_out);
                    check_field("sda_out", want.sda_out, res.data.sda_out);
                    check_field("busy_res", want.busy_res, res.data.busy_res);
                    check_field("done_res", want.done_res, res.data.done_res);
                    check_field("nack", want.nack, res.data.nack);
                end
            end
            if (cfg_wr_en)
                delay_ticks = cfg_wr_data;
            if (cmd.valid && cmd.ready)
                expected_res.push_back(probe_tick(cmd.data));
        end
        queued = expected_res.size();
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives tick transactions into the I2C address probe master: a directed
// opening, then phases of random probes at several bus delays, with random
// gaps on both channels and one long result stall. Checking is done by the
// checker instance; this module gives the verdict.
// ----------------------------------------------------------------------------
module testbench;
    import i2cap_pkg::*;

    localparam int IDLE_MAX    = 11;
    localparam int LONG_HOLD   = 200;
    localparam int PHASES      = 8;
    localparam int PHASE_TICKS = 190;
    localparam int LIMIT       = 400000;

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_wr_en;
    logic [DELAY_W-1:0] cfg_wr_data;

    int mismatches;
    int pending;
    int cycles;
    bit idle_on;
    bit stall_on;
    bit long_hold;

    i2cap_cmd_if cmd ();
    i2cap_res_if res ();

    i2c_address_probe_master DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .res         (res)
    );

    i2cap_checker probe_check (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd         (cmd),
        .res         (res),
        .mismatches  (mismatches),
        .pending     (pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // offer one tick and hold it until the transaction completes
    task automatic send_tick(bit go, logic [ADDR_W-1:0] addr, bit sda);
        int gap;
        gap = idle_on ? $urandom_range(0, IDLE_MAX) : 0;
        repeat (gap)
        begin
            cmd.valid <= 1'b0;
            @(posedge clk);
        end
        cmd.valid       <= 1'b1;
        cmd.data.go      <= go;
        cmd.data.address <= addr;
        cmd.data.sda_in  <= sda;
        @(posedge clk);
        while (!cmd.ready)
            @(posedge clk);
    endtask

    task automatic set_delay(logic [DELAY_W-1:0] value);
        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (2) @(posedge clk);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // result side: random stalls, plus one long hold on request
    initial
    begin
        int gap;
        res.ready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (long_hold)
            begin
                res.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
                long_hold = 1'b0;
            end
            gap = stall_on ? $urandom_range(0, IDLE_MAX) : 0;
            if (gap > 0)
            begin
                res.ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            res.ready <= 1'b1;
            @(posedge clk);
            while (!res.valid)
                @(posedge clk);
        end
    end

    initial
    begin
        cycles = 0;
        while (cycles < LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("testbench: FAIL");
        $finish;
    end

    initial
    begin
        logic [DELAY_W-1:0] d;
        int                 deff;
        int                 n;
        int                 len;
        rst_n       = 1'b0;
        cfg_wr_en   = 1'b0;
        cfg_wr_data = '0;
        cmd.valid   = 1'b0;
        cmd.data    = '0;
        idle_on     = 1'b1;
        stall_on    = 1'b1;
        long_hold   = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // idle: lines released, nack still 1 from reset
        send_tick(1'b0, 7'h00, 1'b1);
        send_tick(1'b0, 7'h7F, 1'b0);
        // probe at the reset delay, go held high is ignored while busy
        send_tick(1'b1, 7'h7F, 1'b1);
        repeat (7)
            send_tick(1'b1, ADDR_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
        // zero delay acts as one, written mid-probe
        set_delay(8'd0);
        // slave answers; go stays high through done and restarts at address 0
        repeat (26) send_tick(1'b1, 7'h00, 1'b0);

        for (int p = 0; p < PHASES; p++)
        begin
            case (p)
                0: d = 8'd1;
                1: d = 8'd0;
                2: d = 8'd2;
                3: d = 8'd255;
                4: d = DELAY_W'($urandom_range(3, 6));
                5: d = 8'd1;
                6: d = DELAY_W'($urandom_range(1, 12));
                default: d = DELAY_RESET;
            endcase
            idle_on  = ($urandom_range(0, 2) != 0);
            stall_on = ($urandom_range(0, 2) != 0);
            set_delay(d);
            if (p == 2)
            begin
                idle_on   = 1'b0;
                long_hold = 1'b1;
            end
            n = 0;
            if (d == 8'd255)
            begin
                // let the last short probe finish, then cover only the first phases
                repeat (50)
                    send_tick(1'b0, ADDR_W'($urandom_range(0, 127)),
                              1'($urandom_range(0, 1)));
                send_tick(1'b1, ADDR_W'($urandom_range(0, 127)), 1'($urandom_range(0, 1)));
                repeat (299)
                    send_tick($urandom_range(0, 19) == 0, ADDR_W'($urandom_range(0, 127)),
                              1'($urandom_range(0, 1)));
            end
            else
            begin
                deff = (d == 0) ? 1 : int'(d);
                while (n < PHASE_TICKS)
                begin
                    if ($urandom_range(0, 9) == 0)
                    begin
                        // noise: random go pattern, may cut in anywhere
                        len = $urandom_range(1, 30);
                        repeat (len)
                            send_tick(1'($urandom_range(0, 1)),
                                      ADDR_W'($urandom_range(0, 127)),
                                      1'($urandom_range(0, 1)));
                    end
                    else
                    begin
                        len = 23 * deff + 1 + $urandom_range(0, 3);
                        send_tick(1'b1, ADDR_W'($urandom_range(0, 127)),
                                  1'($urandom_range(0, 1)));
                        repeat (len - 1)
                            send_tick($urandom_range(0, 15) == 0,
                                      ADDR_W'($urandom_range(0, 127)),
                                      1'($urandom_range(0, 1)));
                    end
                    n += len;
                end
            end
        end

        cmd.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        if (mismatches == 0)
            $display("testbench: PASS");
        else
            $display("testbench: FAIL");
        $finish;
    end

endmodule

FILE: i2c_address_probe_master.f
sv/i2cap_pkg.sv
sv/i2cap_if.sv
sv/i2cap_seq.sv
sv/i2cap_out_reg.sv
sv/i2c_address_probe_master.sv
sv/i2cap_checker.sv
tb/i2cap_checker.sv
tb/testbench.sv
